@@ sv/htd_pkg.sv @@
// Shared types, constants and helper functions for the hypergraph triangle detector.
`timescale 1ns / 1ps

package htd_pkg;

   // Storage sizing.
   localparam int EDGE_CAPACITY = 64;
   localparam int IDX_W         = $clog2(EDGE_CAPACITY);
   localparam int CNT_W         = $clog2(EDGE_CAPACITY + 1);

   // Field widths.
   localparam int KIND_W   = 2;
   localparam int EDGE_W   = 12;
   localparam int HEAD_W   = 4;
   localparam int HELD_W   = 7;

   // Item kinds.
   typedef logic [KIND_W-1:0] kind_type;
   localparam kind_type KIND_CLEAR  = 2'd0;
   localparam kind_type KIND_APPEND = 2'd1;
   localparam kind_type KIND_TEST   = 2'd2;

   // Input item.
   typedef struct packed {
      kind_type            kind;
      logic [EDGE_W-1:0]   edge_mask;
      logic [HEAD_W-1:0]   head;
      logic                directed;
      logic [HEAD_W-1:0]   vertex;
   } req_type;

   // Result item.
   typedef struct packed {
      logic                found;
      logic [HELD_W-1:0]   edges_held;
      logic                overflow;
   } rsp_type;

   // One stored edge, as held in the edge memory.
   typedef struct packed {
      logic [EDGE_W-1:0]   vset;
      logic [HEAD_W-1:0]   head;
      logic                directed;
   } edge_type;

   localparam int EDGE_BITS = $bits(edge_type);

   // Search sequencer states.
   typedef enum logic [1:0] {
      SRCH_IDLE,
      SRCH_EDGE_I,
      SRCH_EDGE_J,
      SRCH_EDGE_K
   } srch_state_type;

   // Status from the search sequencer to the top level.
   typedef struct packed {
      logic busy;
      logic done;
      logic found;
   } srch_status_type;

   // Number of set bits in a vertex set.
   function automatic logic [3:0] count_bits(input logic [EDGE_W-1:0] x);
      logic [3:0] n;
      n = '0;
      for (int b = 0; b < EDGE_W; b++) begin
         n = n + 4'(x[b]);
      end
      return n;
   endfunction

   // Vertex set holding just vertex v; empty when v is above the last vertex.
   function automatic logic [EDGE_W-1:0] vertex_bit(input logic [HEAD_W-1:0] v);
      logic [2**HEAD_W-1:0] w;
      w    = '0;
      w[v] = 1'b1;
      return w[EDGE_W-1:0];
   endfunction

endpackage

@@ sv/htd_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module htd_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 16
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [DATA_W-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [DATA_W-1:0]         rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/htd_search.sv @@
// Search sequencer: walks edge pairs and third edges out of the edge memory.
`timescale 1ns / 1ps

module htd_search (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        go,
   input  logic [htd_pkg::HEAD_W-1:0]  vertex,
   input  logic [htd_pkg::CNT_W-1:0]   edge_total,
   input  htd_pkg::edge_type           rd_data,
   output logic [htd_pkg::IDX_W-1:0]   rd_addr,
   output htd_pkg::srch_status_type    status
);

   import htd_pkg::*;

   srch_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  i_ff, i_in;
   logic [CNT_W-1:0]  j_ff, j_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   edge_type          ei_ff, ei_in;
   edge_type          ej_ff, ej_in;
   logic [EDGE_W-1:0] vmask_ff, vmask_in;

   logic [CNT_W-1:0]  rd_idx;
   logic [CNT_W:0]    i_plus2, j_plus1, k_plus1;
   logic [EDGE_W-1:0] pair_diff, span, stem, xyz;
   logic              has_vertex, pair_ok, third_ok, head_hit;
   logic              adv_j, adv_i, finish, found;

   // State and payload registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SRCH_IDLE;
      end else begin
         state_ff <= state_in;
      end
      i_ff     <= i_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
      ei_ff    <= ei_in;
      ej_ff    <= ej_in;
      vmask_ff <= vmask_in;
   end

   // Tests on the edge that the memory returns this cycle.
   always_comb begin
      has_vertex = |(rd_data.vset & vmask_ff);
      pair_diff  = ei_ff.vset ^ rd_data.vset;
      pair_ok    = has_vertex && (count_bits(pair_diff) == 4'd2);
      span       = (ei_ff.vset ^ ej_ff.vset) | ei_ff.vset;
      stem       = (ei_ff.vset ^ ej_ff.vset) ^ rd_data.vset;
      xyz        = (ei_ff.vset | ej_ff.vset | rd_data.vset) & ~stem;
      head_hit   = (ei_ff.directed && |(xyz & vertex_bit(ei_ff.head)))
                || (ej_ff.directed && |(xyz & vertex_bit(ej_ff.head)))
                || (rd_data.directed && |(xyz & vertex_bit(rd_data.head)));
      third_ok   = (k_ff != i_ff) && (k_ff != j_ff)
                && (count_bits(span ^ rd_data.vset) == 4'd1) && head_hit;
      i_plus2    = {1'b0, i_ff} + (CNT_W+1)'(2);
      j_plus1    = {1'b0, j_ff} + (CNT_W+1)'(1);
      k_plus1    = {1'b0, k_ff} + (CNT_W+1)'(1);
   end

   // Next state, loop indexes and memory read address.
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      ei_in    = ei_ff;
      ej_in    = ej_ff;
      vmask_in = vmask_ff;
      rd_idx   = i_ff;
      adv_j    = 1'b0;
      adv_i    = 1'b0;
      finish   = 1'b0;
      found    = 1'b0;

      case (state_ff)
         SRCH_IDLE: begin
            if (go) begin
               vmask_in = vertex_bit(vertex);
               i_in     = '0;
               rd_idx   = '0;
               if (edge_total >= CNT_W'(2)) begin
                  state_in = SRCH_EDGE_I;
               end else begin
                  finish = 1'b1;
               end
            end
         end
         SRCH_EDGE_I: begin
            if (has_vertex) begin
               ei_in    = rd_data;
               j_in     = i_ff + CNT_W'(1);
               rd_idx   = i_ff + CNT_W'(1);
               state_in = SRCH_EDGE_J;
            end else begin
               adv_i = 1'b1;
            end
         end
         SRCH_EDGE_J: begin
            if (pair_ok) begin
               ej_in    = rd_data;
               k_in     = '0;
               rd_idx   = '0;
               state_in = SRCH_EDGE_K;
            end else begin
               adv_j = 1'b1;
            end
         end
         SRCH_EDGE_K: begin
            if (third_ok) begin
               finish = 1'b1;
               found  = 1'b1;
            end else if (k_plus1 < {1'b0, edge_total}) begin
               k_in   = k_plus1[CNT_W-1:0];
               rd_idx = k_plus1[CNT_W-1:0];
            end else begin
               adv_j = 1'b1;
            end
         end
         default: begin
            state_in = SRCH_IDLE;
         end
      endcase

      // Advance j to the next candidate, or fall through to advancing i.
      if (adv_j) begin
         if (j_plus1 < {1'b0, edge_total}) begin
            j_in     = j_plus1[CNT_W-1:0];
            rd_idx   = j_plus1[CNT_W-1:0];
            state_in = SRCH_EDGE_J;
         end else begin
            adv_i = 1'b1;
         end
      end

      // Move to the next first edge, or end the search without a hit.
      if (adv_i) begin
         if (i_plus2 < {1'b0, edge_total}) begin
            i_in     = i_ff + CNT_W'(1);
            rd_idx   = i_ff + CNT_W'(1);
            state_in = SRCH_EDGE_I;
         end else begin
            finish = 1'b1;
         end
      end

      if (finish) begin
         state_in = SRCH_IDLE;
      end
   end

   assign rd_addr      = rd_idx[IDX_W-1:0];
   assign status.busy  = (state_ff != SRCH_IDLE);
   assign status.done  = finish;
   assign status.found = found;

endmodule

@@ sv/hypergraph_triangle_detect_top.sv @@
// Top level of the hypergraph triangle detector: edge list, counters and result register.
`timescale 1ns / 1ps

// Usage:
// An item is transferred on req_data at a rising edge where start is high and
// busy is low. Kind clear empties the edge list and the overflow flag, kind
// append stores one edge (or sets the sticky overflow flag when the list is
// full), kind test searches for a generalized triangle through req_data.vertex.
// Every item gives one result on rsp_data, marked by rsp_valid for exactly one
// cycle; the receiver has no way to stall it and must take it in that cycle.
// Clear, append and unused kinds answer in the cycle after the transfer, and the
// block is ready again in that same cycle. A test holds busy while the search
// runs: it reads one stored edge per cycle from the edge memory, whose single
// read port sets the pace. The result appears in the cycle after the search
// ends. Reset empties the list and clears the overflow flag and all control
// state; the edge memory itself is not cleared.

module hypergraph_triangle_detect_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  htd_pkg::req_type req_data,
   output logic             rsp_valid,
   output htd_pkg::rsp_type rsp_data
);

   import htd_pkg::*;

   logic [CNT_W-1:0] total_ff, total_in;
   logic             ovf_ff, ovf_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             accept, go, wr_en;
   logic [IDX_W-1:0] rd_addr;
   logic [EDGE_BITS-1:0] rd_bits;
   edge_type         wr_edge;
   srch_status_type  srch_status;

   assign accept = start && !srch_status.busy;
   assign go     = accept && (req_data.kind == KIND_TEST);
   assign busy   = srch_status.busy;

   assign wr_edge.vset     = req_data.edge_mask;
   assign wr_edge.head     = req_data.head;
   assign wr_edge.directed = req_data.directed;

   // Edge memory.
   htd_ram #(
      .DATA_W (EDGE_BITS),
      .DEPTH  (EDGE_CAPACITY)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (total_ff[IDX_W-1:0]),
      .wr_data (wr_edge),
      .rd_addr (rd_addr),
      .rd_data (rd_bits)
   );

   // Triangle search sequencer.
   htd_search u_search (
      .clock      (clock),
      .reset      (reset),
      .go         (go),
      .vertex     (req_data.vertex),
      .edge_total (total_ff),
      .rd_data    (edge_type'(rd_bits)),
      .rd_addr    (rd_addr),
      .status     (srch_status)
   );

   // Edge count, overflow flag and the result of each item.
   always_comb begin
      total_in     = total_ff;
      ovf_in       = ovf_ff;
      wr_en        = 1'b0;
      rsp_valid_in = srch_status.done;
      if (accept) begin
         case (req_data.kind)
            KIND_CLEAR: begin
               total_in = '0;
               ovf_in   = 1'b0;
            end
            KIND_APPEND: begin
               if (total_ff < CNT_W'(EDGE_CAPACITY)) begin
                  wr_en    = 1'b1;
                  total_in = total_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
         if (req_data.kind != KIND_TEST) begin
            rsp_valid_in = 1'b1;
         end
      end
      rsp_data_in.found      = srch_status.done && srch_status.found;
      rsp_data_in.edges_held = HELD_W'(total_in);
      rsp_data_in.overflow   = ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ sim/hypergraph_triangle_detect_checker.sv @@
// Result checker for the hypergraph triangle detector: edge-list predictor and scoreboard.
`timescale 1ns / 1ps

module hypergraph_triangle_detect_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  htd_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  htd_pkg::rsp_type rsp_data,
   output int               mismatch_count,
   output int               pending_count
);

   import htd_pkg::*;

   // Predicted edge list and status flags.
   logic [EDGE_W-1:0] model_sets     [EDGE_CAPACITY];
   logic [HEAD_W-1:0] model_heads    [EDGE_CAPACITY];
   logic              model_directed [EDGE_CAPACITY];
   int                model_count;
   logic              model_overflow;

   // Results still owed by the block, oldest first.
   rsp_type           owed_results[$];
   int                fail_total;

   // A stored edge contributes only when directed and its head lies in the open vertices.
   function automatic logic head_hits(input int idx, input logic [EDGE_W-1:0] xyz);
      logic [2**HEAD_W-1:0] wide;
      wide = '0;
      wide[EDGE_W-1:0] = xyz;
      if (!model_directed[idx]) begin
         return 1'b0;
      end
      return wide[model_heads[idx]];
   endfunction

   // Search every pair i < j through the vertex and every other stored set k for a triangle.
   function automatic logic triangle_through(input logic [HEAD_W-1:0] v);
      logic [2**HEAD_W-1:0] vmask;
      logic [EDGE_W-1:0]    vbit;
      logic [EDGE_W-1:0]    ei, ej, ek, m, span, stem, xyz;
      vmask    = '0;
      vmask[v] = 1'b1;
      vbit     = vmask[EDGE_W-1:0];
      for (int i = 0; i + 1 < model_count; i++) begin
         ei = model_sets[i];
         if ((ei & vbit) == '0) continue;
         for (int j = i + 1; j < model_count; j++) begin
            ej = model_sets[j];
            if ((ej & vbit) == '0) continue;
            m = ei ^ ej;
            if ($countones(m) != 2) continue;
            span = m | ei;
            for (int k = 0; k < model_count; k++) begin
               if (k == i || k == j) continue;
               ek = model_sets[k];
               if ($countones(span ^ ek) != 1) continue;
               stem = m ^ ek;
               xyz  = (ei | ej | ek) & ~stem;
               if (head_hits(i, xyz) || head_hits(j, xyz) || head_hits(k, xyz)) begin
                  return 1'b1;
               end
            end
         end
      end
      return 1'b0;
   endfunction

   // Apply one transferred item to the predicted state and return the result it owes.
   function automatic rsp_type apply_item(input req_type r);
      rsp_type res;
      res = '0;
      case (r.kind)
         KIND_CLEAR: begin
            model_count    = 0;
            model_overflow = 1'b0;
         end
         KIND_APPEND: begin
            if (model_count < EDGE_CAPACITY) begin
               model_sets[model_count]     = r.edge_mask;
               model_heads[model_count]    = r.head;
               model_directed[model_count] = r.directed;
               model_count++;
            end else begin
               model_overflow = 1'b1;
            end
         end
         KIND_TEST: begin
            res.found = triangle_through(r.vertex);
         end
         default: begin
         end
      endcase
      res.edges_held = model_count[HELD_W-1:0];
      res.overflow   = model_overflow;
      return res;
   endfunction

   // Count a failure; only the first few are described.
   task automatic note_failure(input string what, input logic have_want,
                               input rsp_type want, input rsp_type got);
      fail_total++;
      if (fail_total <= 10) begin
         if (have_want) begin
            $write("%t %s: expected found=%0d held=%0d overflow=%0d",
                   $realtime, what, want.found, want.edges_held, want.overflow);
            $display(", got found=%0d held=%0d overflow=%0d",
                     got.found, got.edges_held, got.overflow);
         end else begin
            $display("%t %s: got found=%0d held=%0d overflow=%0d", $realtime, what,
                     got.found, got.edges_held, got.overflow);
         end
      end
   endtask

   // Predict on each input transfer and compare each result transfer with the oldest one owed.
   always @(posedge clock) begin
      rsp_type want;
      rsp_type owed;
      if (reset) begin
         model_count    = 0;
         model_overflow = 1'b0;
         owed_results.delete();
      end else begin
         if (start && !busy) begin
            owed = apply_item(req_data);
            owed_results.insert(owed_results.size(), owed);
         end
         if (rsp_valid) begin
            if (owed_results.size() == 0) begin
               note_failure("result with none owed", 1'b0, '0, rsp_data);
            end else begin
               want = owed_results.pop_front();
               if (want !== rsp_data) begin
                  note_failure("result mismatch", 1'b1, want, rsp_data);
               end
            end
         end
      end
      pending_count  <= owed_results.size();
      mismatch_count <= fail_total;
   end

endmodule

@@ sim/hypergraph_triangle_detect_top_tb.sv @@
// Testbench top for the hypergraph triangle detector: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module hypergraph_triangle_detect_top_tb;

   import htd_pkg::*;

   localparam int       RUN_LIMIT    = 30_000_000;
   localparam int       DRAIN_CYCLES = 20;
   localparam int       RANDOM_ITEMS = 15;
   localparam kind_type KIND_UNUSED  = 2'd3;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   int      mismatch_count;
   int      pending_count;
   int      cycle_count   = 0;
   bit      idle_on       = 1'b1;
   int      edges_in_list = 0;
   int      items_sent    = 0;

   always #5 clock = ~clock;

   hypergraph_triangle_detect_top uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   hypergraph_triangle_detect_checker result_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // Guard against a hung block.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("** hypergraph_triangle_detect_top: FAILED **");
         $finish;
      end
   end

   function automatic req_type make_item(input kind_type k, input logic [EDGE_W-1:0] s,
                                         input logic [HEAD_W-1:0] h, input logic d,
                                         input logic [HEAD_W-1:0] v);
      req_type r;
      r.kind      = k;
      r.edge_mask = s;
      r.head      = h;
      r.directed  = d;
      r.vertex    = v;
      return r;
   endfunction

   // Hold start until the transfer, then maybe leave a short gap.
   task automatic send_item(input req_type r);
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (r.kind == KIND_CLEAR) begin
         edges_in_list = 0;
      end else if (r.kind == KIND_APPEND && edges_in_list < EDGE_CAPACITY) begin
         edges_in_list++;
      end
      if (r.kind != KIND_UNUSED) begin
         items_sent++;
      end
      if (idle_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Unused fields carry random values so that every input bit moves.
   task automatic append_edge(input logic [EDGE_W-1:0] s, input logic [HEAD_W-1:0] h,
                              input logic d);
      send_item(make_item(KIND_APPEND, s, h, d, HEAD_W'($urandom_range(0, 15))));
   endtask

   task automatic test_vertex(input logic [HEAD_W-1:0] v);
      send_item(make_item(KIND_TEST, EDGE_W'($urandom_range(0, 4095)),
                          HEAD_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), v));
   endtask

   task automatic clear_list();
      send_item(make_item(KIND_CLEAR, EDGE_W'($urandom_range(0, 4095)),
                          HEAD_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                          HEAD_W'($urandom_range(0, 15))));
   endtask

   task automatic send_unused();
      send_item(make_item(KIND_UNUSED, EDGE_W'($urandom_range(0, 4095)),
                          HEAD_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                          HEAD_W'($urandom_range(0, 15))));
   endtask

   task automatic append_random();
      append_edge(EDGE_W'($urandom_range(0, 4095)), HEAD_W'($urandom_range(0, 15)),
                  1'($urandom_range(0, 1)));
   endtask

   // Stop sending until every result owed has come back.
   task automatic hold_off();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // A triangle-shaped trio of sets through one vertex, in random order with noise
   // appends between them, followed by tests. Sometimes the last set built is broken.
   task automatic run_cluster();
      logic [HEAD_W-1:0] v;
      logic [EDGE_W-1:0] trio [3];
      logic [EDGE_W-1:0] swap_set;
      int                a, b, c, pick;
      if ($urandom_range(0, 7) == 0) begin
         v = HEAD_W'($urandom_range(12, 15));
      end else begin
         v = HEAD_W'($urandom_range(0, 11));
      end
      do a = $urandom_range(0, 11); while (a == v);
      do b = $urandom_range(0, 11); while (b == v || b == a);
      c = $urandom_range(0, 11);
      trio[0] = EDGE_W'($urandom_range(0, 4095));
      if (v < EDGE_W) begin
         trio[0][v] = 1'b1;
      end
      trio[1] = trio[0];
      trio[1][a] = ~trio[1][a];
      trio[1][b] = ~trio[1][b];
      trio[2] = trio[0] | trio[1];
      trio[2][c] = ~trio[2][c];
      if ($urandom_range(0, 5) == 0) begin
         pick = $urandom_range(0, 11);
         trio[2][pick] = ~trio[2][pick];
      end
      for (int n = 2; n > 0; n--) begin
         pick       = $urandom_range(0, n);
         swap_set   = trio[n];
         trio[n]    = trio[pick];
         trio[pick] = swap_set;
      end
      for (int n = 0; n < 3; n++) begin
         if ($urandom_range(0, 2) == 0) begin
            append_random();
         end
         append_edge(trio[n], HEAD_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      end
      test_vertex(v);
      if ($urandom_range(0, 1) == 0) begin
         test_vertex(HEAD_W'($urandom_range(0, 15)));
      end
      if ($urandom_range(0, 5) == 0) begin
         send_unused();
      end
   endtask

   initial begin
      int random_goal;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty list, extreme fields, unused kind, then hand-built triangles.
      test_vertex(4'd0);
      append_edge(12'hFFF, 4'd15, 1'b1);
      append_edge(12'h000, 4'd0, 1'b0);
      send_unused();
      test_vertex(4'd15);
      test_vertex(4'd11);
      clear_list();
      // Stem on vertex 2; heads outside the open vertices or undirected find nothing.
      append_edge(12'h007, 4'd2, 1'b0);
      append_edge(12'h00D, 4'd5, 1'b1);
      append_edge(12'h00E, 4'd3, 1'b0);
      test_vertex(4'd0);
      // A duplicate edge whose head lies above the last vertex.
      append_edge(12'h00E, 4'd12, 1'b1);
      test_vertex(4'd0);
      // A duplicate whose head lies in the open vertices completes the triangle.
      append_edge(12'h00E, 4'd3, 1'b1);
      test_vertex(4'd0);
      test_vertex(4'd2);
      // Triangle among the high vertices, head on the first edge.
      append_edge(12'hC00, 4'd9, 1'b1);
      append_edge(12'hF00, 4'd0, 1'b0);
      append_edge(12'hF80, 4'd0, 1'b0);
      test_vertex(4'd11);
      test_vertex(4'd10);
      clear_list();
      hold_off();

      // Random: triangle clusters, some broken, on small lists, with clears and noise.
      random_goal = items_sent + RANDOM_ITEMS;
      while (items_sent < random_goal) begin
         if (edges_in_list > 12 || $urandom_range(0, 5) == 0) begin
            clear_list();
         end
         run_cluster();
         if ($urandom_range(0, 9) == 0) begin
            hold_off();
         end
      end

      // Fill the list past capacity, search the full list, then clear the sticky flag.
      clear_list();
      while (edges_in_list < EDGE_CAPACITY) append_random();
      repeat (3) append_random();
      test_vertex(HEAD_W'($urandom_range(0, 11)));
      test_vertex(HEAD_W'($urandom_range(0, 11)));
      send_unused();
      clear_list();
      append_random();

      // Last stretch with no gaps.
      idle_on = 1'b0;
      clear_list();
      repeat (3) run_cluster();
      hold_off();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("** hypergraph_triangle_detect_top: PASSED **");
      end else begin
         $display("** hypergraph_triangle_detect_top: FAILED **");
      end
      $finish;
   end

endmodule
